/* design/aarm_pkg.sv */
// Shared constants, types and helpers for the axis-angle rotation matrix block.
package aarm_pkg;

  // CORDIC depth, clamped to the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                         ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);

  // square root: 33 result bits, one per cell
  localparam int SQ_BITS = 33;
  // division: quotient below 2^45, one bit per cell
  localparam int DV_BITS = 45;

  localparam int SQ_LAT  = SQ_BITS;
  localparam int DV_LAT  = DV_BITS;
  localparam int FRONT   = 1 + SQ_LAT + DV_LAT;
  localparam int BACK    = 5;
  localparam int LAT     = FRONT + BACK;
  localparam int CORDIC_DELAY = FRONT - 1 - NSTEP;

  localparam logic signed [31:0] Q28_ONE     = 32'sd268435456;
  localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
  localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
  localparam logic signed [31:0] Q28_TWO_PI  = 32'sd1686629713;
  localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;

  // one CORDIC cell's working set
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               flip;
  } cordic_t;

  // square root cell state
  typedef struct packed {
    logic [65:0] rem;
    logic [32:0] root;
    logic [47:0] n;
  } sqrt_t;

  // divider cell state (three components in parallel)
  typedef struct packed {
    logic [2:0][45:0] rem;
    logic [2:0][44:0] quo;
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic [32:0]      r;
  } div_t;

  function automatic logic signed [31:0] atan_q28(input int i);
    logic signed [31:0] t;
    unique case (i)
      0: t = 32'sd210828714;  1: t = 32'sd124459457;  2: t = 32'sd65760959;
      3: t = 32'sd33381290;   4: t = 32'sd16755422;   5: t = 32'sd8385879;
      6: t = 32'sd4193963;    7: t = 32'sd2097109;    8: t = 32'sd1048571;
      9: t = 32'sd524287;     10: t = 32'sd262144;    11: t = 32'sd131072;
      12: t = 32'sd65536;     13: t = 32'sd32768;     14: t = 32'sd16384;
      15: t = 32'sd8192;      16: t = 32'sd4096;      17: t = 32'sd2048;
      18: t = 32'sd1024;      19: t = 32'sd512;       20: t = 32'sd256;
      21: t = 32'sd128;       22: t = 32'sd64;        23: t = 32'sd32;
      default: t = 32'sd0;
    endcase
    return t;
  endfunction

  // round Q.28 to Q1.14 and saturate
  function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
    logic signed [35:0] e;
    e = (v + 36'sd8192) >>> 14;
    if (e > 36'sd32767) return 16'sh7fff;
    if (e < -36'sd32768) return 16'sh8000;
    return e[15:0];
  endfunction

endpackage

/* design/aarm_cordic_cell.sv */
// One CORDIC rotation cell: fixed shift and arctangent per position.
module aarm_cordic_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [4:0]         step,
  input  aarm_pkg::cordic_t  d_in,
  output aarm_pkg::cordic_t  d_out
);
  aarm_pkg::cordic_t d_nxt;
  logic signed [31:0] dx, dy, at;

  always_comb begin
    dx = d_in.y >>> step;
    dy = d_in.x >>> step;
    at = aarm_pkg::atan_q28(int'(step));
    d_nxt = d_in;
    if (!d_in.z[31]) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end
  end

  // hold while the chain is stalled
  always_ff @(posedge clk) begin
    if (en) d_out <= d_nxt;
  end
endmodule

/* design/aarm_sqrt_cell.sv */
// One restoring square-root cell: settles one result bit.
module aarm_sqrt_cell (
  input  logic              clk,
  input  logic              en,
  input  logic [5:0]        bitpos,
  input  aarm_pkg::sqrt_t   d_in,
  output aarm_pkg::sqrt_t   d_out
);
  aarm_pkg::sqrt_t d_nxt;
  logic [65:0] trial, cand;
  logic [79:0] nn;

  // value q<<32 is n with 32 zero bits below; bring down two bits per cell
  always_comb begin
    nn    = {d_in.n, 32'd0};
    cand  = {d_in.rem[63:0], nn[{bitpos, 1'b1}], nn[{bitpos, 1'b0}]};
    trial = {31'd0, d_in.root, 2'b01};
    d_nxt = d_in;
    if (cand >= trial) begin
      d_nxt.rem  = cand - trial;
      d_nxt.root = {d_in.root[31:0], 1'b1};
    end else begin
      d_nxt.rem  = cand;
      d_nxt.root = {d_in.root[31:0], 1'b0};
    end
  end

  // hold while the chain is stalled
  always_ff @(posedge clk) begin
    if (en) d_out <= d_nxt;
  end
endmodule

/* design/aarm_div_cell.sv */
// One restoring divider cell: one quotient bit for each of three components.
module aarm_div_cell (
  input  logic             clk,
  input  logic             en,
  input  logic [5:0]       bitpos,
  input  aarm_pkg::div_t   d_in,
  output aarm_pkg::div_t   d_out
);
  aarm_pkg::div_t d_nxt;
  logic [60:0] num [3];
  logic [45:0] cand [3];

  // dividend is mag<<44, its bits above 44 preloaded as the remainder;
  // bring down one bit per cell
  always_comb begin
    d_nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      num[k]  = {d_in.mag[k], 45'd0} >> 1;
      cand[k] = {d_in.rem[k][44:0], num[k][bitpos]};
      if (cand[k] >= {13'd0, d_in.r}) begin
        d_nxt.rem[k] = cand[k] - {13'd0, d_in.r};
        d_nxt.quo[k] = {d_in.quo[k][43:0], 1'b1};
      end else begin
        d_nxt.rem[k] = cand[k];
        d_nxt.quo[k] = {d_in.quo[k][43:0], 1'b0};
      end
    end
  end

  // hold while the chain is stalled
  always_ff @(posedge clk) begin
    if (en) d_out <= d_nxt;
  end
endmodule

/* design/axis_angle_rotation_matrix.sv */
// Top level: axis-angle to 3x3 rotation matrix, pipelined Rodrigues form.
//
// A fully pipelined chain of cells that accepts one request every cycle while
// the output is not stalled and returns one matrix per request in order. The
// path runs through 33 square-root cells, one bit each, and 45 divider cells
// for the axis normalisation; the CORDIC cells run alongside. Back-pressure
// stalls the whole chain; a skid register on the input keeps tready
// registered. A zero axis gives the identity with axis_zero set.
module axis_angle_rotation_matrix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // angle, axis_x, axis_y, axis_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // m00 m10 m20 m01 m11 m21 m02 m12 m22
  output logic         out_tuser   // axis_zero
);
  localparam int L = aarm_pkg::LAT;

  // skid stage
  logic        skid_v_r;
  logic [63:0] skid_d_r;
  logic        adv;
  logic        src_v;
  logic [63:0] src_d;
  logic [L-1:0] vld_r;
  logic         out_full;

  assign out_full  = vld_r[L-1];
  assign adv       = !out_full || out_tready;
  assign in_tready = !skid_v_r;
  assign src_v     = skid_v_r || in_tvalid;
  assign src_d     = skid_v_r ? skid_d_r : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_v_r <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && !adv) skid_d_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], src_v};
    end
  end

  // stage 0: unpack, range reduce, sum of squares
  logic signed [15:0] ang, ax, ay, az;
  logic signed [31:0] zr;
  logic signed [33:0] z0, z1;
  logic               flp;
  logic [47:0]        q0;
  assign ang = src_d[15:0];
  assign ax  = src_d[31:16];
  assign ay  = src_d[47:32];
  assign az  = src_d[63:48];

  always_comb begin
    z0 = {{2{ang[15]}}, ang, 16'd0};
    flp = 1'b0;
    if (z0 > 34'(aarm_pkg::Q28_PI)) z0 = z0 - 34'(aarm_pkg::Q28_TWO_PI);
    else if (z0 < -34'(aarm_pkg::Q28_PI)) z0 = z0 + 34'(aarm_pkg::Q28_TWO_PI);
    z1 = z0;
    if (z0 > 34'(aarm_pkg::Q28_HALF_PI)) begin
      z1 = z0 - 34'(aarm_pkg::Q28_PI); flp = 1'b1;
    end else if (z0 < -34'(aarm_pkg::Q28_HALF_PI)) begin
      z1 = z0 + 34'(aarm_pkg::Q28_PI); flp = 1'b1;
    end
    zr = z1[31:0];
    q0 = 48'(ax * ax) + 48'(ay * ay) + 48'(az * az);
  end

  aarm_pkg::cordic_t cr0_r;
  aarm_pkg::sqrt_t   sq0_r;
  logic [2:0][15:0]  a0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cr0_r <= '{x: aarm_pkg::Q28_GAIN, y: 32'sd0, z: zr, flip: flp};
      sq0_r <= '{rem: '0, root: '0, n: q0};
      a0_r  <= {az, ay, ax};
    end
  end

  // CORDIC chain of cells, then delay to line up with the divider output
  aarm_pkg::cordic_t cch [aarm_pkg::NSTEP+1];
  aarm_pkg::cordic_t cdl_r [aarm_pkg::CORDIC_DELAY+1];
  assign cch[0] = cr0_r;
  for (genvar i = 0; i < aarm_pkg::NSTEP; i++) begin : g_cordic
    aarm_cordic_cell u_cell (.clk(clk), .en(adv), .step(5'(i)), .d_in(cch[i]),
                             .d_out(cch[i+1]));
  end
  assign cdl_r[0] = cch[aarm_pkg::NSTEP];
  for (genvar i = 0; i < aarm_pkg::CORDIC_DELAY; i++) begin : g_cdl
    always_ff @(posedge clk) begin
      if (adv) cdl_r[i+1] <= cdl_r[i];
    end
  end

  // square root chain
  aarm_pkg::sqrt_t sch [aarm_pkg::SQ_BITS+1];
  logic [2:0][15:0] asq_r [aarm_pkg::SQ_BITS+1];
  assign sch[0] = sq0_r;
  assign asq_r[0] = a0_r;
  for (genvar i = 0; i < aarm_pkg::SQ_BITS; i++) begin : g_sqrt
    aarm_sqrt_cell u_cell (.clk(clk), .en(adv), .bitpos(6'(aarm_pkg::SQ_BITS-1-i)),
                           .d_in(sch[i]), .d_out(sch[i+1]));
    always_ff @(posedge clk) begin
      if (adv) asq_r[i+1] <= asq_r[i];
    end
  end

  // divider chain; remainder starts with the dividend bits above the quotient
  aarm_pkg::div_t dch [aarm_pkg::DV_BITS+1];
  aarm_pkg::div_t dv0;
  always_comb begin
    dv0.rem = '0;
    dv0.quo = '0;
    dv0.r   = sch[aarm_pkg::SQ_BITS].root;
    for (int k = 0; k < 3; k++) begin
      dv0.neg[k] = asq_r[aarm_pkg::SQ_BITS][k][15];
      dv0.mag[k] = asq_r[aarm_pkg::SQ_BITS][k][15] ?
                   16'(-asq_r[aarm_pkg::SQ_BITS][k]) : asq_r[aarm_pkg::SQ_BITS][k];
      dv0.rem[k] = {31'd0, dv0.mag[k][15:1]};
    end
  end
  assign dch[0] = dv0;
  for (genvar i = 0; i < aarm_pkg::DV_BITS; i++) begin : g_div
    aarm_div_cell u_cell (.clk(clk), .en(adv), .bitpos(6'(aarm_pkg::DV_BITS-1-i)),
                          .d_in(dch[i]), .d_out(dch[i+1]));
  end

  // back end: unit vector, products, entries
  aarm_pkg::div_t    dv_end;
  aarm_pkg::cordic_t cs_end;
  assign dv_end = dch[aarm_pkg::DV_BITS];
  assign cs_end = cdl_r[aarm_pkg::CORDIC_DELAY];

  logic signed [31:0] u_r [3];
  logic signed [31:0] c_r, s_r;
  logic               zero_r [aarm_pkg::BACK];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= dv_end.neg[k] ? -32'(dv_end.quo[k]) : 32'(dv_end.quo[k]);
      end
      c_r <= cs_end.flip ? -cs_end.x : cs_end.x;
      s_r <= cs_end.flip ? -cs_end.y : cs_end.y;
      zero_r[0] <= (dv_end.mag == '0);
    end
  end

  // products ui*uj and uk*s
  logic signed [31:0] uu_r [3][3];
  logic signed [31:0] us_r [3];
  logic signed [31:0] c2_r, omc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          uu_r[i][j] <= 32'((64'(u_r[i]) * 64'(u_r[j])) >>> 28);
        end
        us_r[i] <= 32'((64'(u_r[i]) * 64'(s_r)) >>> 28);
      end
      c2_r  <= c_r;
      omc_r <= aarm_pkg::Q28_ONE - c_r;
      zero_r[1] <= zero_r[0];
    end
  end

  logic signed [31:0] t_r [3][3];
  logic signed [31:0] us2_r [3];
  logic signed [31:0] c3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t_r[i][j] <= 32'((64'(uu_r[i][j]) * 64'(omc_r)) >>> 28);
        end
      end
      us2_r <= us_r;
      c3_r  <= c2_r;
      zero_r[2] <= zero_r[1];
    end
  end

  // sums: entry m(r)(c) = t[c][r] with sine terms per formula
  logic signed [35:0] e_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0] <= 36'(c3_r) + 36'(t_r[0][0]);
      e_r[1] <= 36'(t_r[0][1]) - 36'(us2_r[2]);
      e_r[2] <= 36'(t_r[0][2]) + 36'(us2_r[1]);
      e_r[3] <= 36'(t_r[1][0]) + 36'(us2_r[2]);
      e_r[4] <= 36'(c3_r) + 36'(t_r[1][1]);
      e_r[5] <= 36'(t_r[1][2]) - 36'(us2_r[0]);
      e_r[6] <= 36'(t_r[2][0]) - 36'(us2_r[1]);
      e_r[7] <= 36'(t_r[2][1]) + 36'(us2_r[0]);
      e_r[8] <= 36'(c3_r) + 36'(t_r[2][2]);
      zero_r[3] <= zero_r[2];
    end
  end

  // rounding, saturation, identity on zero axis
  logic [143:0] m_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        if (zero_r[3]) m_r[16*k +: 16] <= (k % 4 == 0) ? 16'd16384 : 16'd0;
        else           m_r[16*k +: 16] <= aarm_pkg::to_q14(e_r[k]);
      end
      zero_r[4] <= zero_r[3];
    end
  end

  assign out_tvalid = out_full;
  assign out_tdata  = m_r;
  assign out_tuser  = zero_r[aarm_pkg::BACK-1];

  // checks
  a_skid_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> $past(!adv)) else $error("skid filled while advancing");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tdata[15:0] == 16'd16384)
    else $error("zero axis not identity");
endmodule

/* dv/tb_top.sv */
// Testbench for the axis-angle rotation matrix block: directed and random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam longint PI28 = 843314857;
  localparam longint HPI28 = 421657428;
  localparam longint TPI28 = 1686629713;

  typedef struct packed {
    logic [15:0] e22, e12, e02, e21, e11, e01, e20, e10, e00;
  } matrix_t;

  typedef struct {
    matrix_t m;
    logic    zero_axis;
  } rot_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;
  logic         out_tuser;

  rot_t   pending_mats[$];
  int     mismatches = 0;
  int     snd_idle = 8;
  int     rcv_idle = 60;
  int     hold_rcv = 0;
  int     quiet = 0;
  logic   timed_out = 0;

  axis_angle_rotation_matrix uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // unsigned integer square root
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_of(longint a, longint unsigned r);
    longint unsigned mag;
    longint u;
    mag = a < 0 ? -a : a;
    u = longint'((mag << 44) / r);
    return a < 0 ? -u : u;
  endfunction

  function automatic logic [15:0] round14(longint v);
    longint e;
    e = fshr(v + 8192, 14);
    if (e > 32767) e = 32767;
    if (e < -32768) e = -32768;
    return e[15:0];
  endfunction

  function automatic longint mul_q28(longint a, longint b);
    return fshr(a * b, 28);
  endfunction

  // rotation matrix for one angle/axis request
  function automatic rot_t rodrigues(logic [63:0] d);
    longint ang, ax, ay, az, z, cx, cy, dx, dy, c, s, omc, ux, uy, uz, t;
    longint unsigned q, r;
    logic flip;
    rot_t o;
    ang = longint'($signed(d[15:0]));
    ax = longint'($signed(d[31:16]));
    ay = longint'($signed(d[47:32]));
    az = longint'($signed(d[63:48]));
    q = ax * ax + ay * ay + az * az;
    o.zero_axis = 0;
    if (q == 0) begin
      o.m = '0;
      o.m.e00 = 16384; o.m.e11 = 16384; o.m.e22 = 16384;
      o.zero_axis = 1;
      return o;
    end
    r = isqrt(q << 32);
    ux = unit_of(ax, r); uy = unit_of(ay, r); uz = unit_of(az, r);
    // range reduction then CORDIC rotation
    z = ang * 65536;
    flip = 0;
    if (z > PI28) z -= TPI28;
    else if (z < -PI28) z += TPI28;
    if (z > HPI28) begin z -= PI28; flip = 1; end
    else if (z < -HPI28) begin z += PI28; flip = 1; end
    cx = 163008219; cy = 0;
    for (int i = 0; i < aarm_pkg::NSTEP; i++) begin
      dx = fshr(cy, i);
      dy = fshr(cx, i);
      t = longint'(aarm_pkg::atan_q28(i));
      if (z >= 0) begin cx -= dx; cy += dy; z -= t; end
      else begin cx += dx; cy -= dy; z += t; end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
    omc = 268435456 - c;
    o.m.e00 = round14(c + mul_q28(mul_q28(ux, ux), omc));
    o.m.e10 = round14(mul_q28(mul_q28(ux, uy), omc) - mul_q28(uz, s));
    o.m.e20 = round14(mul_q28(mul_q28(ux, uz), omc) + mul_q28(uy, s));
    o.m.e01 = round14(mul_q28(mul_q28(uy, ux), omc) + mul_q28(uz, s));
    o.m.e11 = round14(c + mul_q28(mul_q28(uy, uy), omc));
    o.m.e21 = round14(mul_q28(mul_q28(uy, uz), omc) - mul_q28(ux, s));
    o.m.e02 = round14(mul_q28(mul_q28(uz, ux), omc) - mul_q28(uy, s));
    o.m.e12 = round14(mul_q28(mul_q28(uz, uy), omc) + mul_q28(ux, s));
    o.m.e22 = round14(c + mul_q28(mul_q28(uz, uz), omc));
    return o;
  endfunction

  // send one request, idling at random first; valid stays up until the next
  // idle cycle or drain
  task automatic send_rotation(logic [15:0] ang, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {z, y, x, ang};
    pending_mats.push_back(rodrigues({z, y, x, ang}));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    while (pending_mats.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_rcv > 0) begin
      hold_rcv <= hold_rcv - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    rot_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = pending_mats.pop_front();
        if (out_tdata !== want.m || out_tuser !== want.zero_axis) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b got %h/%b", want.m, want.zero_axis,
                     out_tdata, out_tuser);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else if (rst_n && (in_tvalid || pending_mats.size() != 0)) quiet <= quiet + 1;
    if (quiet >= WATCHDOG && !timed_out) begin
      timed_out <= 1;
      $display("axis_angle_rotation_matrix verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] ext[6] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h0100};
    // zero axis, all-extreme axes, angle extremes and quadrant edges
    send_rotation(16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_rotation(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    foreach (ext[i]) send_rotation(ext[i], ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6]);
    send_rotation(16'd6434, 16'h0100, 16'h0000, 16'h0000);
    send_rotation(16'd12868, 16'h0000, 16'h0100, 16'h0000);
    send_rotation(-16'sd12868, 16'h0000, 16'h0000, 16'h0100);
    send_rotation(16'd6433, 16'h8000, 16'h8000, 16'h8000);
    send_rotation(-16'sd6435, 16'h7fff, 16'h7fff, 16'h7fff);
    send_rotation(16'd25736, 16'h0001, 16'h0001, 16'h0000);
    send_rotation(-16'sd25736, 16'h0000, 16'hffff, 16'h0001);
    send_rotation(16'd20000, 16'h0100, 16'h0100, 16'h0100);
    drain_results();
  endtask

  // random requests: mostly short axes, some full range, some zero
  task automatic test_random(int n);
    logic [15:0] a[3];
    for (int k = 0; k < n; k++) begin
      for (int j = 0; j < 3; j++) begin
        case ($urandom_range(9))
          0: a[j] = 16'h0000;
          1, 2, 3: a[j] = 16'($urandom);
          default: a[j] = 16'(int'($urandom_range(1024)) - 512);
        endcase
      end
      if ($urandom_range(49) == 0) a = '{16'h0000, 16'h0000, 16'h0000};
      send_rotation(16'($urandom), a[0], a[1], a[2]);
    end
  endtask

  // receiver stalls while the sender keeps offering, then sender waits for drain
  task automatic test_backpressure();
    in_tvalid <= 0;
    hold_rcv <= 300;
    @(posedge clk);
    test_random(150);
    drain_results();
    test_random(20);
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(300);
    snd_idle = 60; rcv_idle = 8;
    test_random(250);
    snd_idle = 0; rcv_idle = 0;
    test_random(200);
    test_backpressure();
    repeat (aarm_pkg::LAT + 20) @(posedge clk);
    if (mismatches == 0 && pending_mats.size() == 0) begin
      $display("axis_angle_rotation_matrix verification clean");
    end else begin
      $display("axis_angle_rotation_matrix verification failed");
    end
    $finish;
  end
endmodule

/* axis_angle_rotation_matrix.f */
design/aarm_pkg.sv
design/aarm_cordic_cell.sv
design/aarm_sqrt_cell.sv
design/aarm_div_cell.sv
design/axis_angle_rotation_matrix.sv
dv/tb_top.sv
